// ----- hdl/wss_pkg.sv -----
// ----------------------------------------------------------------------------
// wss_pkg
// Types and constants shared by the wildcard signature scanner modules.
// ----------------------------------------------------------------------------
package wss_pkg;

    localparam int MAX_PATTERN_DEF  = 64;
    localparam int OFFSET_WIDTH_DEF = 32;

    localparam int BYTE_W       = 8;
    localparam int LENGTH_W     = 7;
    localparam int INDEX_W      = 6;
    localparam int OUT_OFFSET_W = 32;

    localparam logic [BYTE_W-1:0] WILDCARD_BYTE = 8'h2A;

    typedef enum logic
    {
        ACT_SIGNATURE = 1'b0,
        ACT_DATA      = 1'b1
    } action_t;

    typedef enum logic
    {
        ST_IDLE = 1'b0,
        ST_EVAL = 1'b1
    } state_t;

    // per-cell control from the sequencer
    typedef struct packed
    {
        logic shift;
        logic clear;
        logic insert;
        logic active;
        logic sig_we;
    } cell_ctrl_t;

endpackage

// ----- hdl/wildcard_signature_scanner_core.sv -----
// A data item is compared in the cycle after acceptance; its result enters
// the output register once that register is free. A signature write is
// taken while idle; no input is taken during a data byte's compare, and the
// compare cycle repeats while a new result waits for the output register.
// Reset: window cleared, position count and match flag zero, length 1, no
// result pending; signature bytes are undefined until written.
// ----------------------------------------------------------------------------
// wildcard_signature_scanner_core
// Streams region bytes through a chain of cells; per region, reports the first
// offset where the stored signature (0x2A matching any byte) matches, or no match.
// ----------------------------------------------------------------------------
module wildcard_signature_scanner_core
#(
    parameter int MAX_PATTERN  = wss_pkg::MAX_PATTERN_DEF,
    parameter int OFFSET_WIDTH = wss_pkg::OFFSET_WIDTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [wss_pkg::LENGTH_W-1:0]        pattern_length,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic [wss_pkg::BYTE_W-1:0]          byte_value,
    input  logic [wss_pkg::INDEX_W-1:0]         pattern_index,
    input  logic                                last_byte,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                found,
    output logic [wss_pkg::OUT_OFFSET_W-1:0]    match_offset
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int CL_W  = (LEN_W > wss_pkg::LENGTH_W) ? LEN_W : wss_pkg::LENGTH_W;
    localparam int EXT_W = ((OFFSET_WIDTH > wss_pkg::OUT_OFFSET_W) ?
                            OFFSET_WIDTH : wss_pkg::OUT_OFFSET_W) + 1;

    wss_pkg::state_t state_reg;
    wss_pkg::state_t state_next;

    logic [LEN_W-1:0]        len_reg;
    logic [LEN_W-1:0]        len_next;
    logic [CL_W-1:0]         len_ext;
    logic [OFFSET_WIDTH-1:0] pos_reg;
    logic [OFFSET_WIDTH-1:0] pos_next;
    logic                    seen_reg;
    logic                    seen_next;
    logic                    last_reg;
    logic                    last_next;
    logic                    fresh_reg;
    logic                    fresh_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    found_reg;
    logic                    found_next;
    logic [wss_pkg::OUT_OFFSET_W-1:0] offset_reg;
    logic [wss_pkg::OUT_OFFSET_W-1:0] offset_next;

    logic                    in_fire;
    logic                    data_fire;
    logic                    sig_fire;
    logic                    eval_en;
    logic                    eval_go;
    logic                    out_free;
    logic                    all_hit;
    logic                    report_hit;
    logic                    report_end;
    logic [EXT_W-1:0]        pos_ext;
    logic [EXT_W-1:0]        n_ext;
    logic [EXT_W-1:0]        diff_ext;

    wss_pkg::cell_ctrl_t        ctrl   [MAX_PATTERN];
    logic [wss_pkg::BYTE_W-1:0] win    [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]     hit;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wss_pkg::ST_IDLE:
            begin
                if (in_valid && action == wss_pkg::ACT_DATA)
                begin
                    state_next = wss_pkg::ST_EVAL;
                end
            end
            wss_pkg::ST_EVAL:
            begin
                // hold the compare while a new result finds the output full
                if (eval_go)
                begin
                    state_next = wss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wss_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        eval_en   = 1'b0;
        unique case (state_reg)
            wss_pkg::ST_IDLE: in_ready = 1'b1;
            wss_pkg::ST_EVAL: eval_en  = 1'b1;
            default:          in_ready = 1'b0;
        endcase
    end

    assign in_fire   = in_valid && in_ready;
    assign data_fire = in_fire && (action == wss_pkg::ACT_DATA);
    assign sig_fire  = in_fire && (action == wss_pkg::ACT_SIGNATURE);

    // ---------------- length register ----------------
    assign len_ext = CL_W'(pattern_length);

    always_comb
    begin
        len_next = len_reg;
        if (cfg_write_en)
        begin
            if (len_ext == '0)
            begin
                len_next = LEN_W'(1);
            end
            else if (len_ext > CL_W'(MAX_PATTERN))
            begin
                len_next = LEN_W'(MAX_PATTERN);
            end
            else
            begin
                len_next = LEN_W'(len_ext);
            end
        end
    end

    // ---------------- cell chain ----------------
    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_cell
        logic [wss_pkg::BYTE_W-1:0] right_win;

        if (i == MAX_PATTERN - 1)
        begin : g_end
            assign right_win = byte_value;
        end
        else
        begin : g_mid
            assign right_win = win[i+1];
        end

        always_comb
        begin
            ctrl[i].shift  = data_fire;
            ctrl[i].clear  = data_fire && fresh_reg;
            ctrl[i].insert = (32'(len_reg) == i + 1);
            ctrl[i].active = (32'(len_reg) > i);
            ctrl[i].sig_we = sig_fire && (32'(pattern_index) == i);
        end

        wss_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl[i]),
            .byte_in   (byte_value),
            .right_win (right_win),
            .win       (win[i]),
            .hit       (hit[i])
        );
    end

    assign all_hit = &hit;

    // ---------------- region state and result ----------------
    assign pos_ext  = EXT_W'(pos_reg);
    assign n_ext    = EXT_W'(len_reg);
    assign diff_ext = pos_ext - n_ext;

    assign report_hit = eval_en && !seen_reg && (pos_ext >= n_ext) && all_hit;
    assign report_end = eval_en && !seen_reg && last_reg && !report_hit;

    assign out_free = !out_valid_reg || out_ready;
    assign eval_go  = eval_en && (out_free || !(report_hit || report_end));

    always_comb
    begin
        pos_next       = pos_reg;
        seen_next      = seen_reg;
        last_next      = last_reg;
        fresh_next     = fresh_reg;
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        offset_next    = offset_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (data_fire)
        begin
            last_next  = last_byte;
            fresh_next = 1'b0;
            // saturate at the top of the count
            if (pos_reg != '1)
            begin
                pos_next = pos_reg + OFFSET_WIDTH'(1);
            end
        end

        if (eval_go && report_hit)
        begin
            seen_next      = 1'b1;
            found_next     = 1'b1;
            offset_next    = diff_ext[wss_pkg::OUT_OFFSET_W-1:0];
            out_valid_next = 1'b1;
        end
        else if (eval_go && report_end)
        begin
            found_next     = 1'b0;
            offset_next    = '0;
            out_valid_next = 1'b1;
        end

        // region over: drop back to the reset state, window on the next byte
        if (eval_go && last_reg)
        begin
            pos_next   = '0;
            seen_next  = 1'b0;
            fresh_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wss_pkg::ST_IDLE;
            len_reg       <= LEN_W'(1);
            pos_reg       <= '0;
            seen_reg      <= 1'b0;
            last_reg      <= 1'b0;
            fresh_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            pos_reg       <= pos_next;
            seen_reg      <= seen_next;
            last_reg      <= last_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg  <= found_next;
        offset_reg <= offset_next;
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign match_offset = offset_reg;

`ifndef SYNTHESIS
    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> match_offset == '0)
        else $error("no-match item carries a non-zero offset");

    a_data_evaluates: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && action == wss_pkg::ACT_DATA |=> state_reg == wss_pkg::ST_EVAL)
        else $error("data byte not followed by a compare cycle");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg != '0 && 32'(len_reg) <= MAX_PATTERN)
        else $error("signature length out of range");

    a_region_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        eval_go && last_reg |=> pos_reg == '0 && !seen_reg)
        else $error("region state not cleared after last byte");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found) && $stable(match_offset))
        else $error("waiting result changed before it was taken");
`endif

endmodule

// ----- hdl/wss_cell.sv -----
// ----------------------------------------------------------------------------
// wss_cell
// One position of the scan chain: a signature byte, a window byte and the
// byte compare with wildcard.
// ----------------------------------------------------------------------------
module wss_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  wss_pkg::cell_ctrl_t           ctrl,
    input  logic [wss_pkg::BYTE_W-1:0]    byte_in,
    input  logic [wss_pkg::BYTE_W-1:0]    right_win,
    output logic [wss_pkg::BYTE_W-1:0]    win,
    output logic                          hit
);

    logic [wss_pkg::BYTE_W-1:0] sig_reg;
    logic [wss_pkg::BYTE_W-1:0] win_reg;
    logic [wss_pkg::BYTE_W-1:0] win_next;

    always_comb
    begin
        win_next = win_reg;
        if (ctrl.shift)
        begin
            // the newest byte lands in the cell at the signature's far end;
            // drop the older bytes on the first byte of a region
            if (ctrl.insert)
            begin
                win_next = byte_in;
            end
            else if (ctrl.clear)
            begin
                win_next = '0;
            end
            else
            begin
                win_next = right_win;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else
        begin
            win_reg <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.sig_we)
        begin
            sig_reg <= byte_in;
        end
    end

    assign win = win_reg;
    assign hit = !ctrl.active || (sig_reg == wss_pkg::WILDCARD_BYTE) || (sig_reg == win_reg);

endmodule

// ----- test/wss_scan_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wss_scan_checker
// Watches the configuration write, the byte channel and the result channel of
// the wildcard signature scanner, predicts each region's result from its own
// copy of the signature, window and position count, and compares every
// result with the oldest one still awaited.
// ----------------------------------------------------------------------------
module wss_scan_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [wss_pkg::LENGTH_W-1:0]        pattern_length,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                action,
    input  logic [wss_pkg::BYTE_W-1:0]          byte_value,
    input  logic [wss_pkg::INDEX_W-1:0]         pattern_index,
    input  logic                                last_byte,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                found,
    input  logic [wss_pkg::OUT_OFFSET_W-1:0]    match_offset,
    output int                                  pending_results,
    output int                                  mismatch_count
);

    typedef struct packed
    {
        logic                             hit;
        logic [wss_pkg::OUT_OFFSET_W-1:0] offset;
    } scan_report_t;

    scan_report_t                         awaited_reports [$];
    bit [wss_pkg::BYTE_W-1:0]             sig_bytes [wss_pkg::MAX_PATTERN_DEF];
    bit [wss_pkg::BYTE_W-1:0]             window [wss_pkg::MAX_PATTERN_DEF];
    bit [wss_pkg::OFFSET_WIDTH_DEF-1:0]   byte_count;
    bit                                   reported;
    bit [wss_pkg::LENGTH_W-1:0]           length_reg;
    int                                   errors = 0;

    function automatic int used_length();
        if (length_reg == 0)
            return 1;
        if (length_reg > wss_pkg::MAX_PATTERN_DEF)
            return wss_pkg::MAX_PATTERN_DEF;
        return int'(length_reg);
    endfunction

    task automatic clear_region();
        for (int i = 0; i < wss_pkg::MAX_PATTERN_DEF; i++)
            window[i] = '0;
        byte_count = '0;
        reported   = 1'b0;
    endtask

    task automatic predict_scan(input logic act, input logic [wss_pkg::BYTE_W-1:0] b,
                                input logic [wss_pkg::INDEX_W-1:0] idx, input logic lst);
        int           n;
        bit           hit;
        scan_report_t rep;
        if (act == wss_pkg::ACT_SIGNATURE)
        begin
            sig_bytes[idx] = b;
        end
        else
        begin
            // entry 0 holds the newest byte
            for (int i = wss_pkg::MAX_PATTERN_DEF - 1; i > 0; i--)
                window[i] = window[i-1];
            window[0] = b;
            if (byte_count != '1)
                byte_count++;
            n   = used_length();
            hit = !reported && (byte_count >= n);
            for (int i = 0; i < n; i++)
                if (sig_bytes[i] != wss_pkg::WILDCARD_BYTE && sig_bytes[i] != window[n-1-i])
                    hit = 1'b0;
            if (hit)
            begin
                reported   = 1'b1;
                rep.hit    = 1'b1;
                rep.offset = byte_count - n;
                awaited_reports.push_back(rep);
            end
            else if (!reported && lst)
            begin
                rep = '0;
                awaited_reports.push_back(rep);
            end
            if (lst)
                clear_region();
        end
    endtask

    task automatic check_report();
        scan_report_t want;
        if (awaited_reports.size() == 0)
        begin
            $display("%0t: unexpected result: expected none, got found=%0d offset=%0d",
                     $time, found, match_offset);
            errors++;
        end
        else
        begin
            want = awaited_reports.pop_front();
            if (found !== want.hit || match_offset !== want.offset)
            begin
                $display("%0t: mismatch: expected found=%0d offset=%0d, got found=%0d offset=%0d",
                         $time, want.hit, want.offset, found, match_offset);
                errors++;
            end
        end
    endtask

    // results are checked before inputs: nothing accepted on this edge can
    // have produced the result leaving on it
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_region();
            length_reg = 7'd1;
            awaited_reports.delete();
            pending_results <= 0;
            mismatch_count  <= errors;
        end
        else
        begin
            if (out_valid && out_ready)
                check_report();
            if (cfg_write_en)
                length_reg = pattern_length;
            if (in_valid && in_ready)
                predict_scan(action, byte_value, pattern_index, last_byte);
            pending_results <= awaited_reports.size();
            mismatch_count  <= errors;
        end
    end

endmodule

// ----- test/wildcard_signature_scanner_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wildcard_signature_scanner_core_tb
// Loads signatures and streams byte regions through the scanner: a short
// directed run over the special cases, then phases at different signature
// lengths with planted, cut-off and noise regions, random idling on both
// sides, a long result stall and drained pauses between phases.
// ----------------------------------------------------------------------------
module wildcard_signature_scanner_core_tb;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 12;
    localparam int LONG_HOLD     = 200;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 120;
    localparam int N_PHASES      = 11;
    localparam int TIMEOUT_NS    = 2_000_000;
    localparam int BYTE_BITS     = wss_pkg::BYTE_W;
    localparam int INDEX_BITS    = wss_pkg::INDEX_W;
    localparam int LENGTH_BITS   = wss_pkg::LENGTH_W;
    localparam int MAX_LEN       = wss_pkg::MAX_PATTERN_DEF;

    logic                              clk            = 1'b0;
    logic                              rst_n          = 1'b0;
    logic                              cfg_write_en   = 1'b0;
    logic [LENGTH_BITS-1:0]            pattern_length = 7'd1;
    logic                              in_valid       = 1'b0;
    logic                              in_ready;
    logic                              action         = wss_pkg::ACT_SIGNATURE;
    logic [BYTE_BITS-1:0]              byte_value     = '0;
    logic [INDEX_BITS-1:0]             pattern_index  = '0;
    logic                              last_byte      = 1'b0;
    logic                              out_valid;
    logic                              out_ready      = 1'b0;
    logic                              found;
    logic [wss_pkg::OUT_OFFSET_W-1:0]  match_offset;

    int                         pending_results;
    int                         mismatch_count;

    logic [BYTE_BITS-1:0]       sig_image [MAX_LEN];
    bit                         sig_loaded [MAX_LEN];
    int                         active_len   = 1;
    int                         phase_items  = 0;
    bit                         idle_on      = 1'b0;
    bit                         hold_req     = 1'b0;
    int                         phase_lengths [N_PHASES] = '{1, 2, 64, 0, 127, 3, 65, 8, 0, 0, 5};

    always #(HALF_PERIOD) clk = ~clk;

    wildcard_signature_scanner_core dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .pattern_length (pattern_length),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .byte_value     (byte_value),
        .pattern_index  (pattern_index),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .match_offset   (match_offset)
    );

    wss_scan_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .pattern_length  (pattern_length),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .byte_value      (byte_value),
        .pattern_index   (pattern_index),
        .last_byte       (last_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .found           (found),
        .match_offset    (match_offset),
        .pending_results (pending_results),
        .mismatch_count  (mismatch_count)
    );

    function automatic logic [BYTE_BITS-1:0] pick_sig_byte();
        logic [BYTE_BITS-1:0] v;
        v = BYTE_BITS'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0)
            v = wss_pkg::WILDCARD_BYTE;
        return v;
    endfunction

    // offer one item and hold it until taken, then maybe idle for a burst
    task automatic send_item(input wss_pkg::action_t act, input logic [BYTE_BITS-1:0] b,
                             input logic [INDEX_BITS-1:0] idx, input logic lst);
        in_valid      <= 1'b1;
        action        <= act;
        byte_value    <= b;
        pattern_index <= idx;
        last_byte     <= lst;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (act == wss_pkg::ACT_SIGNATURE)
        begin
            sig_image[idx]  = b;
            sig_loaded[idx] = 1'b1;
        end
        phase_items++;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // stop offering until every awaited result is out and the block is quiet
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_length(input int v);
        cfg_write_en   <= 1'b1;
        pattern_length <= LENGTH_BITS'(v);
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        if (v == 0)
            active_len = 1;
        else if (v > MAX_LEN)
            active_len = MAX_LEN;
        else
            active_len = v;
    endtask

    // every signature entry in use must be written before any byte is compared
    task automatic load_signature();
        for (int i = 0; i < active_len; i++)
            if (!sig_loaded[i])
                send_item(wss_pkg::ACT_SIGNATURE, pick_sig_byte(), INDEX_BITS'(i),
                          1'($urandom_range(0, 1)));
    endtask

    // one region: mostly a planted signature, sometimes cut off by the end,
    // sometimes plain noise; the odd signature write lands mid-region
    task automatic scan_region();
        int                   n;
        int                   len;
        int                   kind;
        int                   start;
        logic [BYTE_BITS-1:0] b;
        n    = active_len;
        kind = $urandom_range(0, 9);
        if ($urandom_range(0, 4) == 0)
            len = $urandom_range(1, n);
        else
            len = $urandom_range(1, n + 12);
        if (kind < 6 && len < n)
            len = n + $urandom_range(0, 8);
        if (kind < 6)
            start = $urandom_range(0, len - n);
        else
            start = $urandom_range(0, len - 1);
        for (int p = 0; p < len; p++)
        begin
            if ($urandom_range(0, 29) == 0)
                send_item(wss_pkg::ACT_SIGNATURE, pick_sig_byte(),
                          INDEX_BITS'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
            if (kind < 8 && p >= start && p - start < n &&
                sig_image[p-start] != wss_pkg::WILDCARD_BYTE)
                b = sig_image[p-start];
            else if ($urandom_range(0, 1) == 1)
                b = sig_image[$urandom_range(0, n - 1)];
            else
                b = BYTE_BITS'($urandom_range(0, 255));
            send_item(wss_pkg::ACT_DATA, b, INDEX_BITS'($urandom_range(0, 63)), p == len - 1);
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 3)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_on = 1'b1;

        // length 1 from reset; last_byte set on a signature write is ignored
        send_item(wss_pkg::ACT_SIGNATURE, 8'hFF, 6'd0, 1'b1);
        send_item(wss_pkg::ACT_DATA, 8'h00, 6'd0, 1'b0);
        send_item(wss_pkg::ACT_DATA, 8'hFF, 6'd0, 1'b0);
        // bytes after a match, the last one included, give nothing
        send_item(wss_pkg::ACT_DATA, 8'hFF, 6'd63, 1'b0);
        send_item(wss_pkg::ACT_DATA, 8'h00, 6'd0, 1'b1);
        send_item(wss_pkg::ACT_DATA, 8'h55, 6'd0, 1'b1);
        // wildcard matching on the region's final byte
        send_item(wss_pkg::ACT_SIGNATURE, wss_pkg::WILDCARD_BYTE, 6'd0, 1'b0);
        send_item(wss_pkg::ACT_DATA, 8'h00, 6'd0, 1'b1);
        send_item(wss_pkg::ACT_SIGNATURE, 8'h00, 6'd63, 1'b1);
        drain_results();

        // zero length behaves as one
        set_length(0);
        send_item(wss_pkg::ACT_DATA, 8'hAB, 6'd0, 1'b1);
        drain_results();

        set_length(3);
        send_item(wss_pkg::ACT_SIGNATURE, 8'hC3, 6'd1, 1'b0);
        send_item(wss_pkg::ACT_SIGNATURE, 8'h3C, 6'd2, 1'b1);
        send_item(wss_pkg::ACT_DATA, 8'h01, 6'd0, 1'b1);
        send_item(wss_pkg::ACT_DATA, 8'hC3, 6'd0, 1'b0);
        send_item(wss_pkg::ACT_DATA, 8'h11, 6'd0, 1'b0);
        send_item(wss_pkg::ACT_DATA, 8'hC3, 6'd0, 1'b0);
        // signature change mid-region counts from the next byte
        send_item(wss_pkg::ACT_SIGNATURE, wss_pkg::WILDCARD_BYTE, 6'd2, 1'b0);
        send_item(wss_pkg::ACT_DATA, 8'h99, 6'd0, 1'b0);
        send_item(wss_pkg::ACT_DATA, 8'hFF, 6'd0, 1'b1);
        drain_results();

        phase_lengths[8] = $urandom_range(4, 63);
        phase_lengths[9] = $urandom_range(1, 127);
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph == N_PHASES - 1)
                idle_on = 1'b0;
            set_length(phase_lengths[ph]);
            load_signature();
            // short signature, frequent results: a long stall backs up the input
            if (ph == 1)
                hold_req = 1'b1;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
                scan_region();
            drain_results();
        end

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
